@@ rtl/dmge_pkg.sv @@
package dmge_pkg;

   localparam int DefNumQubits = 4;

   // command kinds
   localparam logic [2:0] KindReset   = 3'd0;
   localparam logic [2:0] KindUnitary = 3'd1;
   localparam logic [2:0] KindCnot    = 3'd2;
   localparam logic [2:0] KindDephase = 3'd3;
   localparam logic [2:0] KindDepol   = 3'd4;
   localparam logic [2:0] KindRead    = 3'd5;

   localparam logic signed [15:0] OneQ14 = 16'sd16384;
   localparam logic [14:0] ProbOne = 15'd16384;

   // floor(x / 6) = (x * RecipSix) >> RecipShift for x below 2^17
   localparam logic [15:0] RecipSix = 16'd43691;
   localparam int RecipShift = 18;

   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
   } cval_type;

   typedef struct packed {
      logic signed [16:0] re;
      logic signed [16:0] im;
   } coef_type;

   typedef struct packed {
      logic signed [17:0] re;
      logic signed [17:0] im;
   } opnd_type;

   // round half up to q1.14 and saturate
   function automatic logic signed [15:0] round_q14(input logic signed [36:0] x);
      logic signed [36:0] y;
      logic signed [22:0] s;
      y = x + 37'sd8192;
      s = 23'(y >>> 14);
      if (s > 23'sd32767) begin
         return 16'sd32767;
      end else if (s < -23'sd32768) begin
         return -16'sd32768;
      end else begin
         return s[15:0];
      end
   endfunction

endpackage

@@ rtl/density_matrix_gate_engine_top.sv @@
// channel   direction  payload
// req_      in         kind, target_qubit, control_qubit, u00..u11 re/im, noise_prob
// rsp_      out        basis_index, probability, last
//
// reset clears the matrix with one write per element, no request taken
// unitary: row pass and column pass through the mac pipeline, then a trace pass, then,
//   if the trace is nonzero, each element in turn through the serial divider
// channel: a setup state, one mac pass, one copy pass, then trace and divide as above
// controlled-not: one permute pass and one copy pass; reset command: clears as above
// read diagonal: states DRead, DLoad, DHold per result, DHold waiting on rsp_ready
module density_matrix_gate_engine_top import dmge_pkg::*; #(
   parameter int NUM_QUBITS = DefNumQubits
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_kind,
   input  logic [2:0]         req_target_qubit,
   input  logic [2:0]         req_control_qubit,
   input  logic signed [15:0] req_u00_re,
   input  logic signed [15:0] req_u00_im,
   input  logic signed [15:0] req_u01_re,
   input  logic signed [15:0] req_u01_im,
   input  logic signed [15:0] req_u10_re,
   input  logic signed [15:0] req_u10_im,
   input  logic signed [15:0] req_u11_re,
   input  logic signed [15:0] req_u11_im,
   input  logic [14:0]        req_noise_prob,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_basis_index,
   output logic signed [15:0] rsp_probability,
   output logic               rsp_last
);

   localparam int NQ     = NUM_QUBITS;
   localparam int AddrW  = 2 * NQ;
   localparam int TraceW = 16 + NQ;
   localparam logic [NQ-1:0] QOne = 1;

   localparam logic [3:0] StClear  = 4'd0;
   localparam logic [3:0] StIdle   = 4'd1;
   localparam logic [3:0] StSetup  = 4'd2;
   localparam logic [3:0] StPass   = 4'd3;
   localparam logic [3:0] StDrain  = 4'd4;
   localparam logic [3:0] StTrace  = 4'd5;
   localparam logic [3:0] StTrDone = 4'd6;
   localparam logic [3:0] StTrChk  = 4'd7;
   localparam logic [3:0] StNRead  = 4'd8;
   localparam logic [3:0] StNStart = 4'd9;
   localparam logic [3:0] StNWait  = 4'd10;
   localparam logic [3:0] StDRead  = 4'd11;
   localparam logic [3:0] StDLoad  = 4'd12;
   localparam logic [3:0] StDHold  = 4'd13;

   localparam logic [2:0] PassRow  = 3'd0;
   localparam logic [2:0] PassCol  = 3'd1;
   localparam logic [2:0] PassChan = 3'd2;
   localparam logic [2:0] PassPerm = 3'd3;
   localparam logic [2:0] PassCopy = 3'd4;

   logic [3:0]         state_ff, state_in;
   logic [AddrW-1:0]   cnt_ff, cnt_in;
   logic [2:0]         pk_ff, pk_in;
   logic signed [TraceW-1:0] tr_ff, tr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               v1_ff, v2_ff, v3_ff, trv_ff;
   logic               issue;

   logic [2:0]         kind_ff;
   logic [NQ-1:0]      tmask_ff, cmask_ff;
   cval_type           u00_ff, u01_ff, u10_ff, u11_ff;
   logic [14:0]        p_ff, keep_ff, qn_ff;
   logic [AddrW-1:0]   wa1_ff, wa2_ff, wa3_ff;
   coef_type           k0_1_ff, k1_1_ff;
   logic               same1_ff;
   cval_type           raw2_ff, raw3_ff;
   logic [5:0]         rsp_idx_ff;
   logic signed [15:0] rsp_prob_ff;
   logic               rsp_last_ff;

   logic               req_accept, t_ok, cnot_ok, cnt_last, diag_last;
   logic [NQ-1:0]      row_i, col_i, r0, r1, c0, c1, r2, c2;
   logic               rb, cb;
   logic [AddrW-1:0]   diag_addr, wa0;
   cval_type           usel0, usel1;
   coef_type           k0_0, k1_0;
   opnd_type           a_opnd, b_opnd;
   logic [15:0]        twop3;
   logic [31:0]        qprod;

   logic               rho_we, work_we;
   logic [AddrW-1:0]   rho_waddr, rho_raddr_a, rho_raddr_b, work_raddr_a, work_raddr_b;
   cval_type           rho_wdata, work_wdata;
   cval_type           rho_rd_a, rho_rd_b, work_rd_a, work_rd_b, mac_out;
   logic               div_start, div_done_re, div_done_im, div_done;
   logic signed [15:0] q_re, q_im;

   assign req_ready  = (state_ff == StIdle);
   assign req_accept = req_valid && req_ready;
   assign t_ok       = (int'(req_target_qubit) < NQ);
   assign cnot_ok    = t_ok && (int'(req_control_qubit) < NQ)
                       && (req_control_qubit != req_target_qubit);
   assign cnt_last   = &cnt_ff;
   assign diag_last  = &cnt_ff[NQ-1:0];
   assign div_start  = (state_ff == StNStart);
   assign div_done   = div_done_re && div_done_im;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pk_in        = pk_ff;
      tr_in        = tr_ff;
      rsp_valid_in = rsp_valid_ff;
      issue        = 1'b0;
      if (trv_ff) begin
         tr_in = tr_ff + TraceW'(rho_rd_a.re);
      end
      unique case (state_ff)
         StClear: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (req_valid) begin
               cnt_in = '0;
               unique case (req_kind) inside
                  KindReset: state_in = StClear;
                  KindUnitary: begin
                     if (t_ok) begin
                        pk_in    = PassRow;
                        state_in = StPass;
                     end
                  end
                  KindCnot: begin
                     if (cnot_ok) begin
                        pk_in    = PassPerm;
                        state_in = StPass;
                     end
                  end
                  KindDephase, KindDepol: begin
                     if (t_ok) begin
                        pk_in    = PassChan;
                        state_in = StSetup;
                     end
                  end
                  KindRead: state_in = StDRead;
                  default: state_in = StIdle;
               endcase
            end
         end
         StSetup: state_in = StPass;
         StPass: begin
            issue  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = StDrain;
            end
         end
         StDrain: begin
            if (!(v1_ff || v2_ff || v3_ff)) begin
               cnt_in = '0;
               unique case (pk_ff)
                  PassRow: begin
                     pk_in    = PassCol;
                     state_in = StPass;
                  end
                  PassCol: begin
                     tr_in    = '0;
                     state_in = StTrace;
                  end
                  PassChan, PassPerm: begin
                     pk_in    = PassCopy;
                     state_in = StPass;
                  end
                  PassCopy: begin
                     tr_in    = '0;
                     state_in = (kind_ff == KindCnot) ? StIdle : StTrace;
                  end
                  default: state_in = StIdle;
               endcase
            end
         end
         StTrace: begin
            cnt_in = cnt_ff + 1'b1;
            if (diag_last) begin
               state_in = StTrDone;
            end
         end
         StTrDone: state_in = StTrChk;
         StTrChk: begin
            cnt_in   = '0;
            state_in = (tr_ff == '0) ? StIdle : StNRead;
         end
         StNRead: state_in = StNStart;
         StNStart: state_in = StNWait;
         StNWait: begin
            if (div_done) begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = cnt_last ? StIdle : StNRead;
            end
         end
         StDRead: state_in = StDLoad;
         StDLoad: begin
            rsp_valid_in = 1'b1;
            state_in     = StDHold;
         end
         StDHold: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               cnt_in       = cnt_ff + 1'b1;
               state_in     = diag_last ? StIdle : StDRead;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // element addressing for the current pass
   always_comb begin
      row_i     = cnt_ff[AddrW-1:NQ];
      col_i     = cnt_ff[NQ-1:0];
      rb        = |(row_i & tmask_ff);
      cb        = |(col_i & tmask_ff);
      r0        = row_i & ~tmask_ff;
      r1        = row_i | tmask_ff;
      c0        = col_i & ~tmask_ff;
      c1        = col_i | tmask_ff;
      r2        = (|(row_i & cmask_ff)) ? (row_i ^ tmask_ff) : row_i;
      c2        = (|(col_i & cmask_ff)) ? (col_i ^ tmask_ff) : col_i;
      diag_addr = {col_i, col_i};
      wa0       = (pk_ff == PassPerm) ? {r2, c2} : cnt_ff;
      if (state_ff == StTrace || state_ff == StDRead) begin
         rho_raddr_a = diag_addr;
      end else if (state_ff == StPass && pk_ff == PassRow) begin
         rho_raddr_a = {r0, col_i};
      end else begin
         rho_raddr_a = cnt_ff;
      end
      rho_raddr_b  = (pk_ff == PassRow) ? {r1, col_i} : {row_i ^ tmask_ff, col_i ^ tmask_ff};
      work_raddr_a = (pk_ff == PassCol) ? {row_i, c0} : cnt_ff;
      work_raddr_b = {row_i, c1};
   end

   // coefficients picked at issue
   always_comb begin
      usel0 = ((pk_ff == PassCol) ? cb : rb) ? u10_ff : u00_ff;
      usel1 = ((pk_ff == PassCol) ? cb : rb) ? u11_ff : u01_ff;
      if (pk_ff == PassChan) begin
         k0_0 = '{re: $signed({2'b00, keep_ff}), im: 17'sd0};
         k1_0 = '{re: $signed({2'b00, qn_ff}), im: 17'sd0};
      end else if (pk_ff == PassCol) begin
         k0_0 = '{re: 17'(usel0.re), im: -17'(usel0.im)};
         k1_0 = '{re: 17'(usel1.re), im: -17'(usel1.im)};
      end else begin
         k0_0 = '{re: 17'(usel0.re), im: 17'(usel0.im)};
         k1_0 = '{re: 17'(usel1.re), im: 17'(usel1.im)};
      end
   end

   // operands once the memory data is back
   always_comb begin
      if (pk_ff == PassCol) begin
         a_opnd = '{re: 18'(work_rd_a.re), im: 18'(work_rd_a.im)};
         b_opnd = '{re: 18'(work_rd_b.re), im: 18'(work_rd_b.im)};
      end else begin
         a_opnd = '{re: 18'(rho_rd_a.re), im: 18'(rho_rd_a.im)};
         b_opnd = '{re: 18'(rho_rd_b.re), im: 18'(rho_rd_b.im)};
         if (pk_ff == PassChan) begin
            if (!same1_ff) begin
               b_opnd = '{re: -18'(rho_rd_a.re), im: -18'(rho_rd_a.im)};
            end else if (kind_ff == KindDepol) begin
               b_opnd = '{re: (18'(rho_rd_b.re) <<< 1) + 18'(rho_rd_a.re),
                          im: (18'(rho_rd_b.im) <<< 1) + 18'(rho_rd_a.im)};
            end else begin
               b_opnd = '{re: 18'(rho_rd_a.re), im: 18'(rho_rd_a.im)};
            end
         end
      end
   end

   // channel weights, q = round(p / 3) for depolarizing
   always_comb begin
      twop3 = {p_ff, 1'b0} + 16'd3;
      qprod = twop3 * RecipSix;
   end

   // write ports
   always_comb begin
      work_we    = v3_ff && (pk_ff == PassRow || pk_ff == PassChan || pk_ff == PassPerm);
      work_wdata = (pk_ff == PassPerm) ? raw3_ff : mac_out;
      if (state_ff == StClear) begin
         rho_we    = 1'b1;
         rho_waddr = cnt_ff;
         rho_wdata = (cnt_ff == '0) ? '{re: OneQ14, im: 16'sd0} : '0;
      end else if (state_ff == StNWait) begin
         rho_we    = div_done;
         rho_waddr = cnt_ff;
         rho_wdata = '{re: q_re, im: q_im};
      end else begin
         rho_we    = v3_ff && (pk_ff == PassCol || pk_ff == PassCopy);
         rho_waddr = wa3_ff;
         rho_wdata = (pk_ff == PassCopy) ? raw3_ff : mac_out;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StClear;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         trv_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         trv_ff       <= (state_ff == StTrace);
      end
   end

   // command capture and datapath registers
   always_ff @(posedge clock) begin
      pk_ff <= pk_in;
      tr_ff <= tr_in;
      if (req_accept) begin
         kind_ff  <= req_kind;
         tmask_ff <= QOne << req_target_qubit;
         cmask_ff <= QOne << req_control_qubit;
         u00_ff   <= '{re: req_u00_re, im: req_u00_im};
         u01_ff   <= '{re: req_u01_re, im: req_u01_im};
         u10_ff   <= '{re: req_u10_re, im: req_u10_im};
         u11_ff   <= '{re: req_u11_re, im: req_u11_im};
         p_ff     <= (req_noise_prob > ProbOne) ? ProbOne : req_noise_prob;
      end
      if (state_ff == StSetup) begin
         keep_ff <= ProbOne - p_ff;
         qn_ff   <= (kind_ff == KindDepol) ? 15'(qprod >> RecipShift) : p_ff;
      end
      wa1_ff   <= wa0;
      wa2_ff   <= wa1_ff;
      wa3_ff   <= wa2_ff;
      k0_1_ff  <= k0_0;
      k1_1_ff  <= k1_0;
      same1_ff <= (rb == cb);
      raw2_ff  <= (pk_ff == PassPerm) ? rho_rd_a : work_rd_a;
      raw3_ff  <= raw2_ff;
      if (state_ff == StDLoad) begin
         rsp_idx_ff  <= 6'(col_i);
         rsp_prob_ff <= rho_rd_a.re;
         rsp_last_ff <= diag_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_basis_index = rsp_idx_ff;
   assign rsp_probability = rsp_prob_ff;
   assign rsp_last        = rsp_last_ff;

   dmge_mem #(.AddrW(AddrW)) u_mem (
      .clock        (clock),
      .rho_we       (rho_we),
      .rho_waddr    (rho_waddr),
      .rho_wdata    (rho_wdata),
      .rho_raddr_a  (rho_raddr_a),
      .rho_raddr_b  (rho_raddr_b),
      .rho_rdata_a  (rho_rd_a),
      .rho_rdata_b  (rho_rd_b),
      .work_we      (work_we),
      .work_waddr   (wa3_ff),
      .work_wdata   (work_wdata),
      .work_raddr_a (work_raddr_a),
      .work_raddr_b (work_raddr_b),
      .work_rdata_a (work_rd_a),
      .work_rdata_b (work_rd_b)
   );

   dmge_mac u_mac (
      .clock   (clock),
      .k0_coef (k0_1_ff),
      .k1_coef (k1_1_ff),
      .a_opnd  (a_opnd),
      .b_opnd  (b_opnd),
      .result  (mac_out)
   );

   dmge_div #(.TraceW(TraceW)) u_div_re (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (rho_rd_a.re),
      .denom (tr_ff),
      .done  (div_done_re),
      .quot  (q_re)
   );

   dmge_div #(.TraceW(TraceW)) u_div_im (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (rho_rd_a.im),
      .denom (tr_ff),
      .done  (div_done_im),
      .quot  (q_im)
   );

`ifndef SYNTH
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StIdle) |-> !(v1_ff || v2_ff || v3_ff))
      else $error("mac pipeline busy while idle");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == StNWait))
      else $error("divider finished outside the divide wait");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDRead || state_ff == StDLoad || state_ff == StDHold)
      |-> !(rho_we || work_we))
      else $error("matrix written during diagonal read");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (state_ff == StIdle))
      else $error("engine not idle after final diagonal result");
`endif

endmodule

@@ rtl/dmge_mac.sv @@
module dmge_mac import dmge_pkg::*; (
   input  logic     clock,
   input  coef_type k0_coef,
   input  coef_type k1_coef,
   input  opnd_type a_opnd,
   input  opnd_type b_opnd,
   output cval_type result
);

   logic signed [34:0] rr0_ff, ii0_ff, ri0_ff, ir0_ff;
   logic signed [34:0] rr1_ff, ii1_ff, ri1_ff, ir1_ff;
   logic signed [36:0] sum_re, sum_im;
   cval_type result_ff;

   // partial products
   always_ff @(posedge clock) begin
      rr0_ff <= k0_coef.re * a_opnd.re;
      ii0_ff <= k0_coef.im * a_opnd.im;
      ri0_ff <= k0_coef.re * a_opnd.im;
      ir0_ff <= k0_coef.im * a_opnd.re;
      rr1_ff <= k1_coef.re * b_opnd.re;
      ii1_ff <= k1_coef.im * b_opnd.im;
      ri1_ff <= k1_coef.re * b_opnd.im;
      ir1_ff <= k1_coef.im * b_opnd.re;
   end

   // complex sum, rounded and saturated
   always_comb begin
      sum_re = 37'(rr0_ff) - 37'(ii0_ff) + 37'(rr1_ff) - 37'(ii1_ff);
      sum_im = 37'(ri0_ff) + 37'(ir0_ff) + 37'(ri1_ff) + 37'(ir1_ff);
   end

   always_ff @(posedge clock) begin
      result_ff.re <= round_q14(sum_re);
      result_ff.im <= round_q14(sum_im);
   end

   assign result = result_ff;

endmodule

@@ rtl/dmge_div.sv @@
module dmge_div #(
   parameter int TraceW = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [15:0]       numer,
   input  logic signed [TraceW-1:0] denom,
   output logic                     done,
   output logic signed [15:0]       quot
);

   localparam int NumW = (TraceW > 30 ? TraceW : 30) + 1;
   localparam int CntW = $clog2(NumW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CntW-1:0]   step_ff, step_in;
   logic [NumW-1:0]   num_ff, num_in;
   logic [TraceW-1:0] rem_ff, rem_in;
   logic [TraceW-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic signed [15:0] quot_ff, quot_in;
   logic [15:0]       mag_abs;
   logic [TraceW-1:0] den_abs;
   logic [TraceW:0]   trial;
   logic              qbit;
   logic [NumW-1:0]   q_fin;

   // restoring division, one quotient bit per cycle
   always_comb begin
      mag_abs = numer[15] ? 16'(-17'(numer)) : 16'(numer);
      den_abs = denom[TraceW-1] ? TraceW'(-denom) : TraceW'(denom);
      trial   = {rem_ff, num_ff[NumW-1]};
      qbit    = (trial >= {1'b0, den_ff});
      q_fin   = {num_ff[NumW-2:0], qbit};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         den_in  = den_abs;
         // quotient sign from both operands
         neg_in  = numer[15] ^ denom[TraceW-1];
         num_in  = NumW'({mag_abs, 14'b0}) + NumW'(den_abs >> 1);
      end else if (busy_ff) begin
         rem_in  = qbit ? TraceW'(trial - {1'b0, den_ff}) : trial[TraceW-1:0];
         num_in  = q_fin;
         step_in = step_ff + 1'b1;
         if (step_ff == CntW'(NumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               quot_in = (q_fin > NumW'(32768)) ? -16'sd32768 : 16'(-q_fin[15:0]);
            end else begin
               quot_in = (q_fin > NumW'(32767)) ? 16'sd32767 : q_fin[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ rtl/dmge_mem.sv @@
module dmge_mem import dmge_pkg::*; #(
   parameter int AddrW = 8
) (
   input  logic             clock,
   input  logic             rho_we,
   input  logic [AddrW-1:0] rho_waddr,
   input  cval_type         rho_wdata,
   input  logic [AddrW-1:0] rho_raddr_a,
   input  logic [AddrW-1:0] rho_raddr_b,
   output cval_type         rho_rdata_a,
   output cval_type         rho_rdata_b,
   input  logic             work_we,
   input  logic [AddrW-1:0] work_waddr,
   input  cval_type         work_wdata,
   input  logic [AddrW-1:0] work_raddr_a,
   input  logic [AddrW-1:0] work_raddr_b,
   output cval_type         work_rdata_a,
   output cval_type         work_rdata_b
);

   cval_type rho_mem [2**AddrW];
   cval_type work_mem [2**AddrW];
   cval_type rho_a_ff, rho_b_ff, work_a_ff, work_b_ff;

   // density matrix
   always_ff @(posedge clock) begin
      if (rho_we) begin
         rho_mem[rho_waddr] <= rho_wdata;
      end
      rho_a_ff <= rho_mem[rho_raddr_a];
      rho_b_ff <= rho_mem[rho_raddr_b];
   end

   // scratch matrix
   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[work_waddr] <= work_wdata;
      end
      work_a_ff <= work_mem[work_raddr_a];
      work_b_ff <= work_mem[work_raddr_b];
   end

   assign rho_rdata_a  = rho_a_ff;
   assign rho_rdata_b  = rho_b_ff;
   assign work_rdata_a = work_a_ff;
   assign work_rdata_b = work_b_ff;

endmodule

@@ tb/density_matrix_gate_engine_top_tb.sv @@
`timescale 1ns / 100ps

module density_matrix_gate_engine_top_tb;
   import dmge_pkg::*;

   localparam int NQ = DefNumQubits;
   localparam int DIM = 1 << NQ;
   localparam int CELLS = DIM * DIM;
   localparam longint CYCLE_LIMIT = 20_000_000;
   localparam int HOLD_CYCLES = 3000;

   // kinds that the block ignores
   localparam logic [2:0] KindSpareA = 3'd6;
   localparam logic [2:0] KindSpareB = 3'd7;

   typedef struct {
      logic [2:0] kind;
      logic [2:0] tq;
      logic [2:0] cq;
      logic signed [15:0] u[8];
      logic [14:0] prob;
   } gate_cmd_type;

   typedef struct {
      logic [5:0] idx;
      logic signed [15:0] prob;
      logic last;
   } diag_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_kind = '0;
   logic [2:0] req_target_qubit = '0;
   logic [2:0] req_control_qubit = '0;
   logic signed [15:0] req_u00_re = '0, req_u00_im = '0, req_u01_re = '0, req_u01_im = '0;
   logic signed [15:0] req_u10_re = '0, req_u10_im = '0, req_u11_re = '0, req_u11_im = '0;
   logic [14:0] req_noise_prob = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [5:0] rsp_basis_index;
   logic signed [15:0] rsp_probability;
   logic rsp_last;

   int errors = 0;
   longint cycles = 0;
   bit steady = 0;
   logic hold_start = 1'b0;
   int hold_left = 0;
   diag_type diag_q[$];

   // matrix copy kept by the predictor
   int rho_re[CELLS], rho_im[CELLS];
   int wk_re[CELLS], wk_im[CELLS];

   density_matrix_gate_engine_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   // ---------------- predictor ----------------
   function automatic int sat16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   function automatic int rnd14(input longint x);
      longint y;
      y = x + 8192;
      if (y >= 0) return sat16(y / 16384);
      return sat16(-((-y + 16383) / 16384));
   endfunction

   function automatic int div_by_trace(input longint z, input longint t);
      longint num, an, at, mag;
      num = z * 16384;
      an = num < 0 ? -num : num;
      at = t < 0 ? -t : t;
      mag = (an + at / 2) / at;
      return sat16(((num < 0) != (t < 0)) ? -mag : mag);
   endfunction

   function automatic void matrix_clear();
      for (int i = 0; i < CELLS; i++) begin
         rho_re[i] = 0;
         rho_im[i] = 0;
      end
      rho_re[0] = 16384;
   endfunction

   function automatic void renormalize();
      longint tr;
      tr = 0;
      for (int i = 0; i < DIM; i++) tr += rho_re[i * DIM + i];
      if (tr == 0) return;
      for (int i = 0; i < CELLS; i++) begin
         rho_re[i] = div_by_trace(rho_re[i], tr);
         rho_im[i] = div_by_trace(rho_im[i], tr);
      end
   endfunction

   // k0*a + k1*b rounded
   function automatic void cmac(input longint k0r, k0i, ar, ai, k1r, k1i, br, bi,
                                output int rr, output int ri);
      rr = rnd14(k0r * ar - k0i * ai + k1r * br - k1i * bi);
      ri = rnd14(k0r * ai + k0i * ar + k1r * bi + k1i * br);
   endfunction

   function automatic void apply_unitary(input int m, input gate_cmd_type c);
      longint ur[2][2], ui[2][2];
      int b, lo, hi;
      for (int k = 0; k < 4; k++) begin
         ur[k / 2][k % 2] = c.u[2 * k];
         ui[k / 2][k % 2] = c.u[2 * k + 1];
      end
      // row pass with U
      for (int r = 0; r < DIM; r++) begin
         b = (r & m) ? 1 : 0;
         lo = r & ~m;
         hi = r | m;
         for (int col = 0; col < DIM; col++)
            cmac(ur[b][0], ui[b][0], rho_re[lo * DIM + col], rho_im[lo * DIM + col],
                 ur[b][1], ui[b][1], rho_re[hi * DIM + col], rho_im[hi * DIM + col],
                 wk_re[r * DIM + col], wk_im[r * DIM + col]);
      end
      // column pass with conjugated entries
      for (int col = 0; col < DIM; col++) begin
         b = (col & m) ? 1 : 0;
         lo = col & ~m;
         hi = col | m;
         for (int r = 0; r < DIM; r++)
            cmac(ur[b][0], -ui[b][0], wk_re[r * DIM + lo], wk_im[r * DIM + lo],
                 ur[b][1], -ui[b][1], wk_re[r * DIM + hi], wk_im[r * DIM + hi],
                 rho_re[r * DIM + col], rho_im[r * DIM + col]);
      end
      renormalize();
   endfunction

   function automatic void apply_cnot(input int cm, input int tm);
      int r2, c2;
      for (int r = 0; r < DIM; r++) begin
         r2 = (r & cm) ? (r ^ tm) : r;
         for (int col = 0; col < DIM; col++) begin
            c2 = (col & cm) ? (col ^ tm) : col;
            wk_re[r2 * DIM + c2] = rho_re[r * DIM + col];
            wk_im[r2 * DIM + c2] = rho_im[r * DIM + col];
         end
      end
      rho_re = wk_re;
      rho_im = wk_im;
   endfunction

   function automatic void apply_noise(input int m, input longint praw, input bit depol);
      longint p, q, keep, sre, sim, zr, zi, wr, wi;
      bit same;
      int idx;
      p = praw > 16384 ? 16384 : praw;
      q = depol ? (2 * p + 3) / 6 : p;
      keep = 16384 - p;
      for (int r = 0; r < DIM; r++) begin
         for (int col = 0; col < DIM; col++) begin
            idx = r * DIM + col;
            zr = rho_re[idx];
            zi = rho_im[idx];
            wr = rho_re[(r ^ m) * DIM + (col ^ m)];
            wi = rho_im[(r ^ m) * DIM + (col ^ m)];
            same = ((r & m) != 0) == ((col & m) != 0);
            if (!depol) begin
               sre = same ? zr : -zr;
               sim = same ? zi : -zi;
            end else if (same) begin
               sre = 2 * wr + zr;
               sim = 2 * wi + zi;
            end else begin
               sre = -zr;
               sim = -zi;
            end
            wk_re[idx] = rnd14(keep * zr + q * sre);
            wk_im[idx] = rnd14(keep * zi + q * sim);
         end
      end
      rho_re = wk_re;
      rho_im = wk_im;
      renormalize();
   endfunction

   function automatic void predict_gate(input gate_cmd_type c);
      bit t_ok;
      diag_type d;
      t_ok = c.tq < NQ;
      case (c.kind)
         KindReset: matrix_clear();
         KindUnitary: if (t_ok) apply_unitary(1 << c.tq, c);
         KindCnot: if (t_ok && c.cq < NQ && c.cq != c.tq) apply_cnot(1 << c.cq, 1 << c.tq);
         KindDephase: if (t_ok) apply_noise(1 << c.tq, c.prob, 1'b0);
         KindDepol: if (t_ok) apply_noise(1 << c.tq, c.prob, 1'b1);
         KindRead: begin
            for (int i = 0; i < DIM; i++) begin
               d.idx = 6'(i);
               d.prob = 16'(rho_re[i * DIM + i]);
               d.last = (i == DIM - 1);
               diag_q.push_back(d);
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------- request driver ----------------
   task automatic send_gate(input gate_cmd_type c);
      req_valid <= 1'b1;
      req_kind <= c.kind;
      req_target_qubit <= c.tq;
      req_control_qubit <= c.cq;
      req_u00_re <= c.u[0];
      req_u00_im <= c.u[1];
      req_u01_re <= c.u[2];
      req_u01_im <= c.u[3];
      req_u10_re <= c.u[4];
      req_u10_im <= c.u[5];
      req_u11_re <= c.u[6];
      req_u11_im <= c.u[7];
      req_noise_prob <= c.prob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_gate(c);
      // random gap after the request
      if (!steady && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic gate_cmd_type make_cmd(input logic [2:0] kind, input logic [2:0] tq,
                                             input logic [2:0] cq, input logic [14:0] prob);
      gate_cmd_type c;
      c.kind = kind;
      c.tq = tq;
      c.cq = cq;
      c.prob = prob;
      for (int k = 0; k < 8; k++) c.u[k] = '0;
      return c;
   endfunction

   function automatic gate_cmd_type with_u(input gate_cmd_type c, input int a, b, d, e,
                                           input int f, g, h, k);
      c.u[0] = 16'(a); c.u[1] = 16'(b); c.u[2] = 16'(d); c.u[3] = 16'(e);
      c.u[4] = 16'(f); c.u[5] = 16'(g); c.u[6] = 16'(h); c.u[7] = 16'(k);
      return c;
   endfunction

   // cos of k*pi/8 in q1.14
   function automatic int cos8(input int k);
      int tbl[16] = '{16384, 15137, 11585, 6270, 0, -6270, -11585, -15137,
                      -16384, -15137, -11585, -6270, 0, 6270, 11585, 15137};
      return tbl[k % 16];
   endfunction

   // unitary [[a, -conj(b)], [b, conj(a)]] from random angles
   function automatic gate_cmd_type random_unitary(input gate_cmd_type c);
      int th, ph, ps, ca, sb, ar, ai, br, bi;
      th = $urandom_range(15);
      ph = $urandom_range(15);
      ps = $urandom_range(15);
      ca = cos8(th);
      sb = cos8(th + 12);
      ar = (ca * cos8(ph)) >>> 14;
      ai = (ca * cos8(ph + 12)) >>> 14;
      br = (sb * cos8(ps)) >>> 14;
      bi = (sb * cos8(ps + 12)) >>> 14;
      return with_u(c, ar, ai, -br, bi, br, bi, ar, -ai);
   endfunction

   // ---------------- result checker ----------------
   task automatic check_diag();
      diag_type d;
      if (diag_q.size() == 0) begin
         report($sformatf("unexpected result index %0d", rsp_basis_index));
         return;
      end
      d = diag_q.pop_front();
      if (rsp_basis_index !== d.idx)
         report($sformatf("basis_index %0d, want %0d", rsp_basis_index, d.idx));
      if (rsp_probability !== d.prob)
         report($sformatf("probability %0d at %0d, want %0d",
                          rsp_probability, d.idx, d.prob));
      if (rsp_last !== d.last)
         report($sformatf("last %0b at %0d, want %0b", rsp_last, d.idx, d.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_diag();
         rsp_ready <= (hold_left == 0) && !hold_start && (steady || $urandom_range(99) >= 30);
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed();
      gate_cmd_type c;
      send_gate(make_cmd(KindRead, 3'd0, 3'd0, 15'd0));
      // x on qubit 0, then h on qubit 1
      send_gate(with_u(make_cmd(KindUnitary, 3'd0, 3'd0, 15'd0), 0, 0, 16384, 0,
                       16384, 0, 0, 0));
      send_gate(with_u(make_cmd(KindUnitary, 3'd1, 3'd0, 15'd0), 11585, 0, 11585, 0,
                       11585, 0, -11585, 0));
      send_gate(make_cmd(KindRead, 3'd0, 3'd0, 15'd0));
      // y gate on the top qubit
      send_gate(with_u(make_cmd(KindUnitary, 3'(NQ - 1), 3'd0, 15'd0), 0, 0, 0, -16384,
                       0, 16384, 0, 0));
      send_gate(make_cmd(KindCnot, 3'd2, 3'd0, 15'd0));
      // control equal to target, and qubits out of range
      send_gate(make_cmd(KindCnot, 3'd1, 3'd1, 15'd0));
      send_gate(make_cmd(KindCnot, 3'd7, 3'd0, 15'd0));
      send_gate(make_cmd(KindCnot, 3'd0, 3'd6, 15'd0));
      send_gate(with_u(make_cmd(KindUnitary, 3'd5, 3'd0, 15'd0), 0, 0, 16384, 0,
                       16384, 0, 0, 0));
      send_gate(make_cmd(KindRead, 3'd0, 3'd0, 15'd0));
      send_gate(make_cmd(KindDephase, 3'd1, 3'd0, 15'd0));
      send_gate(make_cmd(KindDephase, 3'd0, 3'd0, ProbOne));
      send_gate(make_cmd(KindDepol, 3'd2, 3'd0, 15'd5000));
      // probability above one saturates
      send_gate(make_cmd(KindDepol, 3'd3, 3'd0, 15'h7fff));
      send_gate(make_cmd(KindDephase, 3'd4, 3'd0, 15'd100));
      send_gate(make_cmd(KindRead, 3'd0, 3'd0, 15'd0));
      send_gate(make_cmd(KindSpareA, 3'd0, 3'd0, 15'd0));
      send_gate(make_cmd(KindSpareB, 3'd1, 3'd2, 15'd0));
      // extreme entries, then an all-zero unitary that leaves a zero trace
      c = with_u(make_cmd(KindUnitary, 3'd0, 3'd0, 15'd0), 32767, 32767, 32767, 32767,
                 32767, 32767, 32767, 32767);
      send_gate(c);
      send_gate(with_u(c, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      send_gate(make_cmd(KindRead, 3'd0, 3'd0, 15'd0));
      send_gate(with_u(c, 0, 0, 0, 0, 0, 0, 0, 0));
      send_gate(make_cmd(KindRead, 3'd0, 3'd0, 15'd0));
      send_gate(make_cmd(KindReset, 3'd0, 3'd0, 15'd0));
   endtask

   // receiver stalls while reads keep coming
   task automatic test_backpressure();
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      for (int i = 0; i < 5; i++) send_gate(make_cmd(KindRead, 3'd0, 3'd0, 15'd0));
   endtask

   task automatic test_random_circuits(input int count);
      gate_cmd_type c;
      int sel;
      for (int n = 0; n < count; n++) begin
         steady = (n >= 100 && n < 150);
         c.tq = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(NQ - 1));
         c.cq = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(NQ - 1));
         c.prob = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(16384));
         for (int k = 0; k < 8; k++) c.u[k] = 16'($urandom);
         sel = $urandom_range(99);
         if (sel < 28) c.kind = KindRead;
         else if (sel < 50) c.kind = KindUnitary;
         else if (sel < 58) begin
            c.kind = KindUnitary;
            c = random_unitary(c);
         end else if (sel < 72) c.kind = KindCnot;
         else if (sel < 82) c.kind = KindDephase;
         else if (sel < 92) c.kind = KindDepol;
         else if (sel < 96) c.kind = KindReset;
         else c.kind = ($urandom_range(1)) ? KindSpareA : KindSpareB;
         // seven in ten of these unitaries are made well formed so the matrix stays meaningful
         if (c.kind == KindUnitary && sel < 50 && $urandom_range(9) < 7) c = random_unitary(c);
         send_gate(c);
      end
      steady = 0;
      send_gate(make_cmd(KindRead, 3'd0, 3'd0, 15'd0));
   endtask

   initial begin
      matrix_clear();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_circuits(240);
      req_valid <= 1'b0;
      while (diag_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/dmge_pkg.sv
rtl/dmge_mac.sv
rtl/dmge_div.sv
rtl/dmge_mem.sv
rtl/density_matrix_gate_engine_top.sv
tb/density_matrix_gate_engine_top_tb.sv
